// ===== src/dssd_pkg.sv =====
package dssd_pkg;

    // width of the incoming binary value
    localparam int unsigned NUM_BITS = 32;
    // decimal digits needed for any 32-bit value
    localparam int unsigned BCD_DIGITS = 10;
    localparam int unsigned BCD_W = 4 * BCD_DIGITS;
    // display positions on the output side
    localparam int unsigned OUT_POS = 8;
    localparam int unsigned SEG_W = 7;
    localparam int unsigned CNT_W = $clog2(NUM_BITS);
    localparam int unsigned DCNT_W = 4;

    // segment codes, a=0x40 b=0x10 c=0x02 d=0x01 e=0x04 f=0x20 g=0x08
    localparam logic [SEG_W-1:0] SEG_0 = 7'h77;
    localparam logic [SEG_W-1:0] SEG_1 = 7'h12;
    localparam logic [SEG_W-1:0] SEG_2 = 7'h5D;
    localparam logic [SEG_W-1:0] SEG_3 = 7'h5B;
    localparam logic [SEG_W-1:0] SEG_4 = 7'h3A;
    localparam logic [SEG_W-1:0] SEG_5 = 7'h6B;
    localparam logic [SEG_W-1:0] SEG_6 = 7'h6F;
    localparam logic [SEG_W-1:0] SEG_7 = 7'h52;
    localparam logic [SEG_W-1:0] SEG_8 = 7'h7F;
    localparam logic [SEG_W-1:0] SEG_9 = 7'h7B;
    localparam logic [SEG_W-1:0] SEG_OFF = 7'h00;

    typedef struct packed {
        logic load;
        logic step;
        logic write;
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;
    } t_dp_sts;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0: seg = SEG_0;
            4'd1: seg = SEG_1;
            4'd2: seg = SEG_2;
            4'd3: seg = SEG_3;
            4'd4: seg = SEG_4;
            4'd5: seg = SEG_5;
            4'd6: seg = SEG_6;
            4'd7: seg = SEG_7;
            4'd8: seg = SEG_8;
            4'd9: seg = SEG_9;
            default: seg = SEG_OFF;
        endcase
        return seg;
    endfunction

endpackage

// ===== src/dssd_dp.sv =====
module dssd_dp #(
    parameter int unsigned DIGIT_COUNT = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  dssd_pkg::t_dp_cmd                             i_cmd,
    output dssd_pkg::t_dp_sts                             o_sts,
    input  logic [dssd_pkg::NUM_BITS-1:0]                 i_number,
    input  logic                                          i_cfg_we,
    input  logic [dssd_pkg::OUT_POS-1:0]                  i_cfg_data,
    output logic [dssd_pkg::OUT_POS-1:0][7:0]             o_pos,
    output logic [dssd_pkg::DCNT_W-1:0]                   o_digits_written
);

    logic [dssd_pkg::NUM_BITS-1:0] r_bin;
    logic [dssd_pkg::BCD_W-1:0]    r_bcd;
    logic [dssd_pkg::BCD_W-1:0]    w_adj;
    logic [dssd_pkg::CNT_W-1:0]    r_cnt;
    logic [dssd_pkg::OUT_POS-1:0]  r_marker;
    logic [dssd_pkg::DCNT_W-1:0]   w_count;

    logic [dssd_pkg::SEG_W-1:0] r_store [DIGIT_COUNT];
    logic [dssd_pkg::SEG_W-1:0] n_store [DIGIT_COUNT];
    logic [dssd_pkg::SEG_W-1:0] w_show  [dssd_pkg::OUT_POS];

    logic [dssd_pkg::OUT_POS-1:0][7:0] r_pos;
    logic [dssd_pkg::DCNT_W-1:0]       r_dw;

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < dssd_pkg::BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // digits up to the most significant nonzero one, at least one,
    // capped at the number of store positions
    always_comb begin
        w_count = 4'd1;
        for (int d = 0; d < dssd_pkg::BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                if (d < int'(DIGIT_COUNT)) begin
                    w_count = dssd_pkg::DCNT_W'(d + 1);
                end else begin
                    w_count = dssd_pkg::DCNT_W'(DIGIT_COUNT);
                end
            end
        end
    end

    always_comb begin
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            n_store[d] = r_store[d];
            if (i_cmd.write && (dssd_pkg::DCNT_W'(d) < w_count)) begin
                n_store[d] = dssd_pkg::seg_of(r_bcd[4*d +: 4]);
            end
        end
    end

    // positions without a store entry show no segments
    for (genvar p = 0; p < dssd_pkg::OUT_POS; p++) begin : g_show
        if (p < DIGIT_COUNT) begin : g_on
            assign w_show[p] = n_store[p];
        end else begin : g_off
            assign w_show[p] = dssd_pkg::SEG_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= '0;
            r_cnt    <= '0;
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                r_store[d] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_marker <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                r_store[d] <= n_store[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_number;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            r_bcd <= {w_adj[dssd_pkg::BCD_W-2:0], r_bin[dssd_pkg::NUM_BITS-1]};
            r_bin <= {r_bin[dssd_pkg::NUM_BITS-2:0], 1'b0};
        end
        if (i_cmd.write) begin
            for (int p = 0; p < dssd_pkg::OUT_POS; p++) begin
                r_pos[p] <= {r_marker[p], w_show[p]};
            end
            r_dw <= w_count;
        end
    end

    assign o_sts.last_step  = (r_cnt == dssd_pkg::CNT_W'(dssd_pkg::NUM_BITS - 1));
    assign o_pos            = r_pos;
    assign o_digits_written = r_dw;

endmodule

// ===== src/dssd_ctrl.sv =====
module dssd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dssd_pkg::t_dp_cmd o_cmd,
    input  dssd_pkg::t_dp_sts i_sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign w_accept   = (r_state == S_IDLE) && i_in_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (w_out_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.write) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV))
        else $error("accepted item did not start conversion");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> !(r_out_valid && i_out_stall))
        else $error("result written over a stalled transfer");

    a_conv_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && i_sts.last_step) |=> (r_state == S_WRITE))
        else $error("conversion did not end after last step");

    a_valid_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WRITE))
        else $error("result valid without a write");

endmodule

// ===== src/decimal_seven_segment_display_writer.sv =====
// per item: load in idle, 32 shift-add-3 steps of the bcd converter, then the
//   store write that sets the result valid, held off while an older result stalls
// the bit-serial bcd conversion loop sets the rate: a new item is taken only
//   after the previous one has been written
// the input is stalled while an item is converting or waiting for its write; a
//   finished result waits in the output register while the next item converts
// reset (synchronous, active low) clears segment store, marker register and control
module decimal_seven_segment_display_writer #(
    parameter int unsigned DIGIT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: marker bits, one per position
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_number,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pos0_segments,
    output logic [7:0]  o_pos1_segments,
    output logic [7:0]  o_pos2_segments,
    output logic [7:0]  o_pos3_segments,
    output logic [7:0]  o_pos4_segments,
    output logic [7:0]  o_pos5_segments,
    output logic [7:0]  o_pos6_segments,
    output logic [7:0]  o_pos7_segments,
    output logic [3:0]  o_digits_written
);

    // command and status between sequencer and datapath
    dssd_pkg::t_dp_cmd w_cmd;
    dssd_pkg::t_dp_sts w_sts;

    // registered display image, position 0 is the units digit
    logic [dssd_pkg::OUT_POS-1:0][7:0] w_pos;

    // sequencer: idle, convert for 32 steps, then write store and result
    dssd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // datapath: double-dabble converter, digit count, segment store, marker
    // register and the output register
    dssd_dp #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_number         (i_number),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_pos            (w_pos),
        .o_digits_written (o_digits_written)
    );

    // bit 7 of each byte is the marker, bits 6..0 the segments
    assign o_pos0_segments = w_pos[0];
    assign o_pos1_segments = w_pos[1];
    assign o_pos2_segments = w_pos[2];
    assign o_pos3_segments = w_pos[3];
    assign o_pos4_segments = w_pos[4];
    assign o_pos5_segments = w_pos[5];
    assign o_pos6_segments = w_pos[6];
    assign o_pos7_segments = w_pos[7];

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // display positions held by the block (matches its default)
    localparam int DIGIT_COUNT = 8;
    // generous stop for a stuck handshake, well above the slowest correct run
    localparam int CYCLE_LIMIT = 1_000_000;
    // random numbers per marker setting
    localparam int PHASE_ITEMS = 200;
    localparam int PHASE_COUNT = 8;

    // one display image: the digit count on top, then positions 7 down to 0
    typedef struct packed {
        logic [3:0]      digits;
        logic [7:0][7:0] pos;
    } t_display_image;

    // predicted display contents plus the queue of images still to come out
    class segment_image_book;
        t_display_image expected_images[$];
        logic [6:0]     store_segs [DIGIT_COUNT];
        logic [7:0]     marker;
        int             mismatches;
        int             images_checked;

        function new();
            marker = 8'h00;
            foreach (store_segs[i]) store_segs[i] = 7'h00;
            mismatches = 0;
            images_checked = 0;
        endfunction

        // segment layout a=0x40 b=0x10 c=0x02 d=0x01 e=0x04 f=0x20 g=0x08
        static function logic [6:0] digit_pattern(input logic [3:0] d);
            case (d)
                4'd0: return 7'h77;
                4'd1: return 7'h12;
                4'd2: return 7'h5D;
                4'd3: return 7'h5B;
                4'd4: return 7'h3A;
                4'd5: return 7'h6B;
                4'd6: return 7'h6F;
                4'd7: return 7'h52;
                4'd8: return 7'h7F;
                4'd9: return 7'h7B;
                default: return 7'h00;
            endcase
        endfunction

        // write the decimal digits of value into the store, units first, up to
        // the top nonzero digit or the last slot; then build the whole image
        function t_display_image predict_image(input logic [31:0] value);
            t_display_image img;
            logic [31:0]    rest;
            logic [6:0]     segs;
            int             count;
            rest = value;
            count = 0;
            do begin
                store_segs[count] = digit_pattern(4'(rest % 10));
                rest = rest / 10;
                count++;
            end while (rest != 0 && count < DIGIT_COUNT);
            for (int i = 0; i < dssd_pkg::OUT_POS; i++) begin
                segs = 7'h00;
                if (i < DIGIT_COUNT) begin
                    segs = store_segs[i];
                end
                img.pos[i] = {marker[i], segs};
            end
            img.digits = 4'(count);
            return img;
        endfunction

        function void note_number(input logic [31:0] value);
            expected_images.push_back(predict_image(value));
        endfunction

        function int pending();
            return expected_images.size();
        endfunction

        function void flag_mismatch(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
            if (mismatches < 10) begin
                $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what,
                         want, got);
            end
            mismatches++;
        endfunction

        function void check_image(input t_display_image got);
            t_display_image want;
            if (expected_images.size() == 0) begin
                flag_mismatch("result with no number pending", '0, got.digits);
                return;
            end
            want = expected_images.pop_front();
            images_checked++;
            for (int i = 0; i < dssd_pkg::OUT_POS; i++) begin
                if (got.pos[i] !== want.pos[i]) begin
                    flag_mismatch($sformatf("pos%0d_segments", i), want.pos[i], got.pos[i]);
                end
            end
            if (got.digits !== want.digits) begin
                flag_mismatch("digits_written", want.digits, got.digits);
            end
        endfunction
    endclass

    // clock, reset and everything driven into the block start at known values
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic [31:0] in_number = 32'h0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [7:0]  pos_seg [8];
    logic [3:0]  digits_written;
    t_display_image seen_image;

    segment_image_book book = new();

    int numbers_sent = 0;
    int marker_writes = 0;
    int cycle_count = 0;

    always #10 clk = ~clk;

    decimal_seven_segment_display_writer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_number         (in_number),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_pos0_segments  (pos_seg[0]),
        .o_pos1_segments  (pos_seg[1]),
        .o_pos2_segments  (pos_seg[2]),
        .o_pos3_segments  (pos_seg[3]),
        .o_pos4_segments  (pos_seg[4]),
        .o_pos5_segments  (pos_seg[5]),
        .o_pos6_segments  (pos_seg[6]),
        .o_pos7_segments  (pos_seg[7]),
        .o_digits_written (digits_written)
    );

    // gather the result fields into one image for the checker
    assign seen_image = {digits_written, pos_seg[7], pos_seg[6], pos_seg[5], pos_seg[4],
                         pos_seg[3], pos_seg[2], pos_seg[1], pos_seg[0]};

    // result side: all driving is nonblocking, so values read here are the
    // ones the block saw at this edge
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            book.check_image(seen_image);
        end
    end

    // watchdog on the whole run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending", cycle_count,
                     book.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall pattern: free-running stretches, random stalls,
    // long blocking stalls and a strictly alternating stall/free pattern
    initial begin : stall_pattern
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int k = 0; k < span; k++) begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2: out_stall <= (k < span / 2);
                    default: out_stall <= k[0];
                endcase
            end
        end
    end

    // numbers for the random part: full range, a chosen digit count,
    // values past eight digits, and values right around powers of ten
    function automatic logic [31:0] random_number();
        logic [31:0] lo;
        logic [31:0] hi;
        int          k;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1, 2: begin
                k = $urandom_range(1, 9);
                lo = 1;
                for (int j = 1; j < k; j++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (k == 1) lo = 0;
                return $urandom_range(hi, lo);
            end
            3: return $urandom_range(32'hFFFF_FFFF, 32'd100_000_000);
            default: begin
                k = $urandom_range(0, 9);
                lo = 1;
                for (int j = 0; j < k; j++) lo = lo * 10;
                return lo - 1 + $urandom_range(0, 2);
            end
        endcase
    endfunction

    // one transfer on the input side; valid stays up if the caller sends again
    task automatic send_number(input logic [31:0] value);
        in_valid <= 1'b1;
        in_number <= value;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        book.note_number(value);
        numbers_sent++;
    endtask

    // stop sending and wait until every pending result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
    endtask

    // marker bits only change while nothing is in flight
    task automatic write_markers(input logic [7:0] bits);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= bits;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.marker = bits;
        marker_writes++;
    endtask

    // random numbers in bursts with random gaps, now and then a full drain
    task automatic send_random_burst_run(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++) begin
                send_number(random_number());
            end
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                in_valid <= 1'b0;
                in_number <= $urandom;
                repeat (gap) @(posedge clk);
            end
            if ($urandom_range(0, 24) == 0) begin
                drain();
            end
        end
    endtask

    // corner numbers: zero, single digits, carries across powers of ten,
    // every digit value, exactly eight digits, too many digits, the 32-bit
    // extremes, and short numbers after long ones so stale upper positions show
    localparam logic [31:0] CORNER_NUMBERS [23] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd5,
        32'd1234567890, 32'd98765432, 32'd99999999, 32'd3, 32'd100000000,
        32'hFFFF_FFFF, 32'h8000_0000, 32'd12345678, 32'd10000000, 32'd7,
        32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 32'd86420, 32'hFFFF_FFFE
    };

    // marker settings per phase, the extremes among them; the entries from
    // index 6 on are replaced by a random value
    localparam logic [7:0] PHASE_MARKERS [PHASE_COUNT] = '{
        8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'h00, 8'h00
    };

    initial begin : stimulus
        logic [7:0] bits;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset marker value, back to back
        foreach (CORNER_NUMBERS[i]) begin
            send_number(CORNER_NUMBERS[i]);
        end
        // every third corner again with all markers on
        write_markers(8'hFF);
        foreach (CORNER_NUMBERS[i]) begin
            if (i % 3 == 0) send_number(CORNER_NUMBERS[i]);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            bits = PHASE_MARKERS[p];
            if (p >= 6) bits = 8'($urandom);
            write_markers(bits);
            send_random_burst_run(PHASE_ITEMS);
        end

        drain();
        // let anything stray come out before the verdict
        repeat (40) @(posedge clk);
        if (book.pending() != 0) begin
            $display("%0d expected results never arrived", book.pending());
        end

        $display("sent %0d numbers over %0d marker settings, %0d display images checked",
                 numbers_sent, marker_writes + 1, book.images_checked);
        $display("mismatches: %0d", book.mismatches);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== decimal_seven_segment_display_writer.f =====
src/dssd_pkg.sv
src/dssd_dp.sv
src/dssd_ctrl.sv
src/decimal_seven_segment_display_writer.sv
verif/tb_top.sv
